@@ design/rtpq_pkg.sv @@
// Shared types and constants for the RFID tag presence qualifier.
package rtpq_pkg;

  // Read kind carried on the input tuser
  typedef enum logic {
    KIND_POLL     = 1'b0,
    KIND_VALIDATE = 1'b1
  } kind_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_TAG_ON        = 3'd1,
    EV_OFF_TIMEOUT   = 3'd2,
    EV_OFF_VALIDATE  = 3'd3,
    EV_PEND_START    = 3'd4,
    EV_PEND_DROP     = 3'd5
  } event_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE_MS     = 3'd0,
    REG_REMOVAL_MS      = 3'd1,
    REG_COOLDOWN_MS     = 3'd2,
    REG_MIN_EMPTY_RM    = 3'd3,
    REG_MIN_CONSISTENT  = 3'd4,
    REG_MAX_EMPTY_RST   = 3'd5,
    REG_VALIDATE_IVL_MS = 3'd6,
    REG_VALIDATE_FAILS  = 3'd7
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;
  localparam int EVENT_W    = 3;

  // Valid UID marker bytes, most significant first
  localparam logic [7:0] UID_TOP_BYTE  = 8'hE0;
  localparam logic [7:0] UID_NEXT_BYTE = 8'h04;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd350;
  localparam logic [15:0] RST_REMOVAL_MS      = 16'd400;
  localparam logic [15:0] RST_COOLDOWN_MS     = 16'd1500;
  localparam logic [7:0]  RST_MIN_EMPTY_RM    = 8'd5;
  localparam logic [7:0]  RST_MIN_CONSISTENT  = 8'd3;
  localparam logic [7:0]  RST_MAX_EMPTY_RST   = 8'd3;
  localparam logic [15:0] RST_VALIDATE_IVL_MS = 16'd800;
  localparam logic [3:0]  RST_VALIDATE_FAILS  = 4'd2;

endpackage

@@ design/rfid_tag_presence_qualifier.sv @@
// RFID tag presence qualifier: turns raw inventory reads into tag on/off events.
//
// Usage:
//   Input stream (in_*): one transaction per reader result. in_tuser holds the
//   read kind (poll or presence validation); in_tdata holds read_ok, the raw
//   UID and the millisecond timestamp. Output stream (out_*): exactly one
//   transaction per input, carrying the event code, the confirmed tag state
//   and the reader reset / RF cycle / validation-due flags.
//   Configuration port (cfg_*): register writes, always accepted; write only
//   while no read is in flight.
// Pipeline:
//   A read is captured in an input register, evaluated by one level of
//   compares and saturating counters, and lands in the output register, which
//   drives out_tvalid. One read per cycle is sustained while out_tready is high;
//   the tag state updates when the read moves to the output register.
// Reset: synchronous, active low; clears all tag state and loads the default
//   configuration.
// Stall: when out_tready is low the output register holds, the input register
//   holds one more read, and in_tready drops once both are full.
module rfid_tag_presence_qualifier
  import rtpq_pkg::*;
#(
  parameter int ID_BITS   = 64,
  parameter int TIME_BITS = 32,
  localparam int InW      = ((1 + ID_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int OutW     = ((EVENT_W + 4 + ID_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [0] read_ok, [ID_BITS:1] uid, then now_ms, zero padded to bytes
  input  logic [InW-1:0]           in_tdata,
  // [0] kind
  input  logic [0:0]               in_tuser,
  // Output stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [2:0] event_res, [3] tag_present, tag_uid, reader_reset_request,
  // rf_cycle_request, validate_due, zero padded to bytes
  output logic [OutW-1:0]          out_tdata,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // Bit positions of the output fields
  localparam int O_PRES = EVENT_W;
  localparam int O_UID  = EVENT_W + 1;
  localparam int O_RST  = EVENT_W + 1 + ID_BITS;
  localparam int O_RFC  = O_RST + 1;
  localparam int O_DUE  = O_RST + 2;

  // Configuration registers
  logic [15:0] debounce_ms_r, removal_ms_r, cooldown_ms_r, validate_ivl_ms_r;
  logic [7:0]  min_empty_rm_r, min_consistent_r, max_empty_rst_r;
  logic [3:0]  validate_fails_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r     <= RST_DEBOUNCE_MS;
      removal_ms_r      <= RST_REMOVAL_MS;
      cooldown_ms_r     <= RST_COOLDOWN_MS;
      min_empty_rm_r    <= RST_MIN_EMPTY_RM;
      min_consistent_r  <= RST_MIN_CONSISTENT;
      max_empty_rst_r   <= RST_MAX_EMPTY_RST;
      validate_ivl_ms_r <= RST_VALIDATE_IVL_MS;
      validate_fails_r  <= RST_VALIDATE_FAILS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE_MS:     debounce_ms_r     <= cfg_data;
        REG_REMOVAL_MS:      removal_ms_r      <= cfg_data;
        REG_COOLDOWN_MS:     cooldown_ms_r     <= cfg_data;
        REG_MIN_EMPTY_RM:    min_empty_rm_r    <= cfg_data[7:0];
        REG_MIN_CONSISTENT:  min_consistent_r  <= cfg_data[7:0];
        REG_MAX_EMPTY_RST:   max_empty_rst_r   <= cfg_data[7:0];
        REG_VALIDATE_IVL_MS: validate_ivl_ms_r <= cfg_data;
        REG_VALIDATE_FAILS:  validate_fails_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Handshake between input register and output register
  logic                 s1_valid_r;
  kind_t                s1_kind_r;
  logic                 s1_ok_r;
  logic [ID_BITS-1:0]   s1_uid_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 out_valid_r;
  logic [OutW-1:0]      out_tdata_r;
  logic                 out_free;
  logic                 s1_move;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Input payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= kind_t'(in_tuser[0]);
      s1_ok_r   <= in_tdata[0];
      s1_uid_r  <= in_tdata[ID_BITS:1];
      s1_now_r  <= in_tdata[ID_BITS+TIME_BITS:ID_BITS+1];
    end
  end

  // Tag tracking state
  logic                 conf_v_r, conf_v_nxt;
  logic [ID_BITS-1:0]   conf_id_r, conf_id_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [ID_BITS-1:0]   pend_id_r, pend_id_nxt;
  logic [TIME_BITS-1:0] pend_start_r, pend_start_nxt;
  logic [7:0]           pend_hits_r, pend_hits_nxt;
  logic [TIME_BITS-1:0] last_seen_r, last_seen_nxt;
  logic [7:0]           empty_reads_r, empty_reads_nxt;
  logic [7:0]           empty_run_r, empty_run_nxt;
  logic                 rem_v_r, rem_v_nxt;
  logic [ID_BITS-1:0]   rem_id_r, rem_id_nxt;
  logic [TIME_BITS-1:0] rem_time_r, rem_time_nxt;
  logic [3:0]           vfail_r, vfail_nxt;
  logic [TIME_BITS-1:0] last_val_r, last_val_nxt;
  logic [OutW-1:0]      out_tdata_nxt;

  // Read qualification: read_ok, nonzero, marker bytes on top
  logic id_valid;
  assign id_valid = s1_ok_r && (s1_uid_r != '0) &&
                    (s1_uid_r[ID_BITS-1 -: 8] == UID_TOP_BYTE) &&
                    (s1_uid_r[ID_BITS-9 -: 8] == UID_NEXT_BYTE);

  // Single-pass evaluation of one read
  always_comb begin
    logic [TIME_BITS-1:0] el_rem;
    logic [TIME_BITS-1:0] el_pend;
    logic [TIME_BITS-1:0] el_seen;
    logic [TIME_BITS-1:0] el_val;
    logic                 ghost;
    event_t               ev;
    logic                 rst_req;
    logic                 rfc_req;
    logic                 due;

    conf_v_nxt      = conf_v_r;
    conf_id_nxt     = conf_id_r;
    pend_v_nxt      = pend_v_r;
    pend_id_nxt     = pend_id_r;
    pend_start_nxt  = pend_start_r;
    pend_hits_nxt   = pend_hits_r;
    last_seen_nxt   = last_seen_r;
    empty_reads_nxt = empty_reads_r;
    empty_run_nxt   = empty_run_r;
    rem_v_nxt       = rem_v_r;
    rem_id_nxt      = rem_id_r;
    rem_time_nxt    = rem_time_r;
    vfail_nxt       = vfail_r;
    last_val_nxt    = last_val_r;
    ev              = EV_NONE;
    rst_req         = 1'b0;
    rfc_req         = 1'b0;

    el_rem  = s1_now_r - rem_time_r;
    el_pend = s1_now_r - pend_start_r;
    el_seen = s1_now_r - last_seen_r;
    ghost   = rem_v_r && (s1_uid_r == rem_id_r) &&
              (el_rem < TIME_BITS'(cooldown_ms_r));

    if (s1_kind_r == KIND_VALIDATE) begin
      // Presence validation, only while a tag is held
      if (conf_v_r) begin
        if (!id_valid || (s1_uid_r != conf_id_r)) begin
          vfail_nxt = (vfail_r == 4'hF) ? vfail_r : vfail_r + 4'd1;
        end else begin
          vfail_nxt = 4'd0;
        end
        if (vfail_nxt >= validate_fails_r) begin
          rem_id_nxt   = conf_id_r;
          rem_v_nxt    = 1'b1;
          rem_time_nxt = s1_now_r;
          conf_v_nxt   = 1'b0;
          conf_id_nxt  = '0;
          vfail_nxt    = 4'd0;
          ev           = EV_OFF_VALIDATE;
          rfc_req      = 1'b1;
        end
        last_val_nxt = s1_now_r;
      end
    end else if (id_valid) begin
      empty_run_nxt = 8'd0;
      if (ghost) begin
        // read of the just-removed tag inside cooldown: ignored
      end else if (conf_v_r && (s1_uid_r == conf_id_r)) begin
        last_seen_nxt   = s1_now_r;
        empty_reads_nxt = 8'd0;
        pend_v_nxt      = 1'b0;
        pend_id_nxt     = '0;
        pend_hits_nxt   = 8'd0;
        vfail_nxt       = 4'd0;
      end else if (pend_v_r && (s1_uid_r == pend_id_r)) begin
        last_seen_nxt   = s1_now_r;
        empty_reads_nxt = 8'd0;
        pend_hits_nxt   = (pend_hits_r == 8'hFF) ? pend_hits_r : pend_hits_r + 8'd1;
        if ((pend_hits_nxt >= min_consistent_r) &&
            (el_pend >= TIME_BITS'(debounce_ms_r))) begin
          conf_v_nxt    = 1'b1;
          conf_id_nxt   = s1_uid_r;
          pend_v_nxt    = 1'b0;
          pend_id_nxt   = '0;
          pend_hits_nxt = 8'd0;
          rem_v_nxt     = 1'b0;
          vfail_nxt     = 4'd0;
          ev            = EV_TAG_ON;
        end
      end else if (!conf_v_r) begin
        last_seen_nxt   = s1_now_r;
        empty_reads_nxt = 8'd0;
        pend_v_nxt      = 1'b1;
        pend_id_nxt     = s1_uid_r;
        pend_start_nxt  = s1_now_r;
        pend_hits_nxt   = 8'd1;
        ev              = EV_PEND_START;
      end
    end else begin
      // Empty or invalid poll read
      empty_reads_nxt = (empty_reads_r == 8'hFF) ? empty_reads_r : empty_reads_r + 8'd1;
      empty_run_nxt   = (empty_run_r == 8'hFF) ? empty_run_r : empty_run_r + 8'd1;
      if (pend_v_r) begin
        pend_v_nxt    = 1'b0;
        pend_id_nxt   = '0;
        pend_hits_nxt = 8'd0;
        ev            = EV_PEND_DROP;
      end
      if (conf_v_r && (empty_reads_nxt >= max_empty_rst_r)) begin
        rst_req         = 1'b1;
        empty_reads_nxt = 8'd0;
      end
      if (conf_v_r && (el_seen >= TIME_BITS'(removal_ms_r)) &&
          (empty_run_nxt >= min_empty_rm_r)) begin
        rem_id_nxt   = conf_id_r;
        rem_v_nxt    = 1'b1;
        rem_time_nxt = s1_now_r;
        conf_v_nxt   = 1'b0;
        conf_id_nxt  = '0;
        vfail_nxt    = 4'd0;
        ev           = EV_OFF_TIMEOUT;
        rfc_req      = 1'b1;
      end
      // Cooldown expiry, seen against the removal time after this read
      if (rem_v_nxt && (TIME_BITS'(s1_now_r - rem_time_nxt) >= TIME_BITS'(cooldown_ms_r))) begin
        rem_v_nxt = 1'b0;
      end
    end

    el_val = s1_now_r - last_val_nxt;
    due    = conf_v_nxt && (el_val >= TIME_BITS'(validate_ivl_ms_r));

    // Result word
    out_tdata_nxt                      = '0;
    out_tdata_nxt[EVENT_W-1:0]         = ev;
    out_tdata_nxt[O_PRES]              = conf_v_nxt;
    out_tdata_nxt[O_UID +: ID_BITS]    = conf_v_nxt ? conf_id_nxt : '0;
    out_tdata_nxt[O_RST]               = rst_req;
    out_tdata_nxt[O_RFC]               = rfc_req;
    out_tdata_nxt[O_DUE]               = due;
  end

  // State commit when the read leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_v_r      <= 1'b0;
      conf_id_r     <= '0;
      pend_v_r      <= 1'b0;
      pend_id_r     <= '0;
      pend_start_r  <= '0;
      pend_hits_r   <= 8'd0;
      last_seen_r   <= '0;
      empty_reads_r <= 8'd0;
      empty_run_r   <= 8'd0;
      rem_v_r       <= 1'b0;
      rem_id_r      <= '0;
      rem_time_r    <= '0;
      vfail_r       <= 4'd0;
      last_val_r    <= '0;
    end else if (s1_move) begin
      conf_v_r      <= conf_v_nxt;
      conf_id_r     <= conf_id_nxt;
      pend_v_r      <= pend_v_nxt;
      pend_id_r     <= pend_id_nxt;
      pend_start_r  <= pend_start_nxt;
      pend_hits_r   <= pend_hits_nxt;
      last_seen_r   <= last_seen_nxt;
      empty_reads_r <= empty_reads_nxt;
      empty_run_r   <= empty_run_nxt;
      rem_v_r       <= rem_v_nxt;
      rem_id_r      <= rem_id_nxt;
      rem_time_r    <= rem_time_nxt;
      vfail_r       <= vfail_nxt;
      last_val_r    <= last_val_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule
